@@ rtl/bcal_pkg.sv @@
// shared types, codes and constants of the bisection calibrator
`timescale 1ns / 1ps

package bcal_pkg;

	// lane count on the ports, lanes in use, and value width
	localparam int NCH        = 6;
	localparam int CHANNELS   = 6;
	localparam int VALUE_BITS = 16;

	typedef logic [VALUE_BITS-1:0] value_t;

	// lanes that are really built and checked
	localparam logic [NCH-1:0] LANE_ACTIVE = NCH'((64'd1 << CHANNELS) - 64'd1);

	// stream packing
	localparam int IN_DATA_BITS  = NCH * VALUE_BITS;
	localparam int OUT_USED_BITS = NCH * VALUE_BITS + NCH + 1;
	localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

	// input item kinds
	localparam logic [1:0] KIND_PAPER  = 2'd0;
	localparam logic [1:0] KIND_VERIFY = 2'd1;
	localparam logic [1:0] KIND_MEAS   = 2'd2;

	// result item events
	localparam logic [1:0] EV_MEASURE    = 2'd0;
	localparam logic [1:0] EV_PAPER_DONE = 2'd1;
	localparam logic [1:0] EV_OPEN_DONE  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_EMISSION    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_EMISSION    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PAPER_REFERENCE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PAPER_TOLERANCE = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_OPEN_REFERENCE  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_OPEN_TOLERANCE  = 3'd5;

	// register reset values
	localparam int MIN_RESET_VAL = 0;
	localparam int MAX_RESET_VAL = 5000;
	localparam value_t MIN_RESET       = value_t'(MIN_RESET_VAL);
	localparam value_t MAX_RESET       = value_t'(MAX_RESET_VAL);
	localparam value_t PAPER_REF_RESET = value_t'(1100);
	localparam value_t PAPER_TOL_RESET = value_t'(100);
	localparam value_t OPEN_REF_RESET  = value_t'(5000);
	localparam value_t OPEN_TOL_RESET  = value_t'(100);
	localparam value_t CHOSEN_RESET    = value_t'((MIN_RESET_VAL + MAX_RESET_VAL) / 2);

	// calibration phase
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SEARCH,
		PH_FINAL,
		PH_VERIFY
	} phase_t;

	// control broadcast to every lane
	typedef struct packed {
		logic   load;
		logic   narrow;
		logic   commit;
		logic   use_chosen;
		value_t min_emission;
		value_t max_emission;
		value_t search_ref;
		value_t check_ref;
		value_t check_tol;
	} lane_ctrl_t;

	// what one lane reports back
	typedef struct packed {
		value_t drive;
		logic   open;
		logic   pass;
	} lane_stat_t;

	// merged per-item outcome from the controller
	typedef struct packed {
		logic           has_result;
		logic [1:0]     event_res;
		logic [NCH-1:0] pass_mask;
		logic           all_pass;
	} merge_t;

	// one result item
	typedef struct packed {
		logic           all_pass;
		logic [NCH-1:0] pass_mask;
		logic [NCH-1:0][VALUE_BITS-1:0] drive;
		logic [1:0]     event_res;
	} result_t;

endpackage

@@ rtl/bcal_lane.sv @@
// one calibration lane: bisection bounds, chosen drive and tolerance check
`timescale 1ns / 1ps

module bcal_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bcal_pkg::lane_ctrl_t ctrl,
	input  bcal_pkg::value_t     reading,
	output bcal_pkg::lane_stat_t stat
);

	bcal_pkg::value_t low_q, high_q, mid_q, chosen_q;
	logic             open_q;

	bcal_pkg::value_t low_n, high_n, req_drive, diff;
	logic [bcal_pkg::VALUE_BITS:0] sum;
	logic             open_n;

	// next bounds: reload on start, halve on a search measurement
	always_comb begin
		low_n  = low_q;
		high_n = high_q;
		if (ctrl.load) begin
			low_n  = ctrl.min_emission;
			high_n = ctrl.max_emission;
		end else if (ctrl.narrow && open_q) begin
			if (reading < ctrl.search_ref) begin
				low_n = mid_q + bcal_pkg::value_t'(1);
			end else begin
				high_n = mid_q;
			end
		end
	end

	// request drive from the new bounds
	always_comb begin
		sum       = {1'b0, low_n} + {1'b0, high_n};
		open_n    = low_n < high_n;
		req_drive = open_n ? sum[bcal_pkg::VALUE_BITS:1] : low_n;
	end

	// absolute deviation check
	always_comb begin
		if (reading >= ctrl.check_ref) begin
			diff = reading - ctrl.check_ref;
		end else begin
			diff = ctrl.check_ref - reading;
		end
	end

	// lane report
	always_comb begin
		if (ctrl.use_chosen) begin
			stat.drive = chosen_q;
		end else if (ctrl.commit) begin
			stat.drive = low_q;
		end else begin
			stat.drive = req_drive;
		end
		stat.open = open_n;
		stat.pass = diff <= ctrl.check_tol;
	end

	// lane state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= '0;
			high_q   <= '0;
			mid_q    <= '0;
			open_q   <= 1'b0;
			chosen_q <= bcal_pkg::CHOSEN_RESET;
		end else begin
			low_q  <= low_n;
			high_q <= high_n;
			mid_q  <= req_drive;
			open_q <= open_n;
			if (ctrl.load) begin
				chosen_q <= '0;
			end else if (ctrl.commit) begin
				chosen_q <= low_q;
			end
		end
	end

	// the final measurement fixes the converged low bound as the drive
	a_commit_low: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |=> chosen_q == $past(low_q))
		else $error("chosen drive does not follow the converged low bound");

endmodule

@@ rtl/bcal_ctrl.sv @@
// configuration registers, phase control and merge of the lane reports
`timescale 1ns / 1ps

module bcal_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bcal_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  bcal_pkg::value_t                    cfg_data,
	input  logic                                take,
	input  logic [1:0]                          kind,
	input  logic [bcal_pkg::NCH-1:0]            lane_open,
	input  logic [bcal_pkg::NCH-1:0]            lane_pass,
	output bcal_pkg::lane_ctrl_t                lane_ctrl,
	output bcal_pkg::merge_t                    merge
);

	bcal_pkg::value_t min_q, max_q, paper_ref_q, paper_tol_q, open_ref_q, open_tol_q;
	bcal_pkg::phase_t phase_q, phase_n;
	logic             any_open;
	logic             is_meas, checking;

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= bcal_pkg::MIN_RESET;
			max_q       <= bcal_pkg::MAX_RESET;
			paper_ref_q <= bcal_pkg::PAPER_REF_RESET;
			paper_tol_q <= bcal_pkg::PAPER_TOL_RESET;
			open_ref_q  <= bcal_pkg::OPEN_REF_RESET;
			open_tol_q  <= bcal_pkg::OPEN_TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bcal_pkg::CFG_MIN_EMISSION:    min_q       <= cfg_data;
				bcal_pkg::CFG_MAX_EMISSION:    max_q       <= cfg_data;
				bcal_pkg::CFG_PAPER_REFERENCE: paper_ref_q <= cfg_data;
				bcal_pkg::CFG_PAPER_TOLERANCE: paper_tol_q <= cfg_data;
				bcal_pkg::CFG_OPEN_REFERENCE:  open_ref_q  <= cfg_data;
				bcal_pkg::CFG_OPEN_TOLERANCE:  open_tol_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// merge of lane convergence
	assign any_open = |(lane_open & bcal_pkg::LANE_ACTIVE);

	// next phase
	always_comb begin
		phase_n = phase_q;
		if (take) begin
			case (kind)
				bcal_pkg::KIND_PAPER:  phase_n = any_open ? bcal_pkg::PH_SEARCH : bcal_pkg::PH_FINAL;
				bcal_pkg::KIND_VERIFY: phase_n = bcal_pkg::PH_VERIFY;
				bcal_pkg::KIND_MEAS: begin
					case (phase_q)
						bcal_pkg::PH_SEARCH: if (!any_open) phase_n = bcal_pkg::PH_FINAL;
						bcal_pkg::PH_FINAL:  phase_n = bcal_pkg::PH_IDLE;
						bcal_pkg::PH_VERIFY: phase_n = bcal_pkg::PH_IDLE;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bcal_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_n;
		end
	end

	// lane control and result merge
	always_comb begin
		is_meas  = kind == bcal_pkg::KIND_MEAS;
		checking = is_meas && (phase_q == bcal_pkg::PH_FINAL || phase_q == bcal_pkg::PH_VERIFY);

		lane_ctrl.load         = take && kind == bcal_pkg::KIND_PAPER;
		lane_ctrl.narrow       = take && is_meas && phase_q == bcal_pkg::PH_SEARCH;
		lane_ctrl.commit       = take && is_meas && phase_q == bcal_pkg::PH_FINAL;
		lane_ctrl.use_chosen   = kind == bcal_pkg::KIND_VERIFY ||
		                         (is_meas && phase_q == bcal_pkg::PH_VERIFY);
		lane_ctrl.min_emission = min_q;
		lane_ctrl.max_emission = max_q;
		lane_ctrl.search_ref   = paper_ref_q;
		lane_ctrl.check_ref    = (phase_q == bcal_pkg::PH_VERIFY) ? open_ref_q : paper_ref_q;
		lane_ctrl.check_tol    = (phase_q == bcal_pkg::PH_VERIFY) ? open_tol_q : paper_tol_q;

		case (kind)
			bcal_pkg::KIND_PAPER:  merge.has_result = 1'b1;
			bcal_pkg::KIND_VERIFY: merge.has_result = 1'b1;
			bcal_pkg::KIND_MEAS:   merge.has_result = phase_q != bcal_pkg::PH_IDLE;
			default:               merge.has_result = 1'b0;
		endcase

		if (is_meas && phase_q == bcal_pkg::PH_FINAL) begin
			merge.event_res = bcal_pkg::EV_PAPER_DONE;
		end else if (is_meas && phase_q == bcal_pkg::PH_VERIFY) begin
			merge.event_res = bcal_pkg::EV_OPEN_DONE;
		end else begin
			merge.event_res = bcal_pkg::EV_MEASURE;
		end

		if (checking) begin
			merge.pass_mask = lane_pass & bcal_pkg::LANE_ACTIVE;
			merge.all_pass  = &(lane_pass | ~bcal_pkg::LANE_ACTIVE);
		end else begin
			merge.pass_mask = '0;
			merge.all_pass  = 1'b0;
		end
	end

	// a done measurement always ends the run
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take && kind == bcal_pkg::KIND_MEAS &&
		(phase_q == bcal_pkg::PH_FINAL || phase_q == bcal_pkg::PH_VERIFY)
		|=> phase_q == bcal_pkg::PH_IDLE)
		else $error("phase not idle after a done measurement");

	// a verify start enters the verify phase from anywhere
	a_verify_enter: assert property (@(posedge clk) disable iff (!arst_n)
		take && kind == bcal_pkg::KIND_VERIFY |=> phase_q == bcal_pkg::PH_VERIFY)
		else $error("verify start did not enter the verify phase");

endmodule

@@ rtl/bcal_obuf.sv @@
// output register with a skid stage for result items
`timescale 1ns / 1ps

module bcal_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bcal_pkg::result_t din,
	output logic              ready,
	output logic              out_valid,
	input  logic              out_ready,
	output bcal_pkg::result_t dout
);

	bcal_pkg::result_t main_q, skid_q;
	logic              main_v_q, skid_v_q;
	logic              pop;

	assign pop       = main_v_q && out_ready;
	assign ready     = !skid_v_q;
	assign out_valid = main_v_q;
	assign dout      = main_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_q <= din;
			end else begin
				main_q <= din;
			end
		end
	end

	// the skid stage only fills behind a held result
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid item without a main item");

	// a result pushed behind a stalled one is parked, not dropped
	a_skid_catch: assert property (@(posedge clk) disable iff (!arst_n)
		push && main_v_q && !out_ready |=> skid_v_q && main_v_q)
		else $error("result lost behind a stalled output");

endmodule

@@ rtl/multichannel_bisection_calibrator.sv @@
// top level of the six-lane bisection drive calibrator
// a result item is registered in the output buffer (in the skid stage first if a held result blocks it)
// throughput: one input item per cycle while s_tready is high; every lane updates its bounds in the accept cycle
// a two-deep output buffer keeps s_tready high while one result waits on m_tready
// reset: async active-low; bounds clear, chosen drives go to the midpoint of the
// reset search range, phase goes idle, config registers take their defaults
`timescale 1ns / 1ps

module multichannel_bisection_calibrator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// reading_ch0 .. reading_ch5, 16 bits each from the lowest bit up
	input  logic [bcal_pkg::IN_DATA_BITS-1:0]      s_tdata,
	// kind
	input  logic [1:0]                             s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// drive_ch0 .. drive_ch5, pass_mask, all_pass, zero pad bit
	output logic [bcal_pkg::OUT_DATA_BITS-1:0]     m_tdata,
	// event_res
	output logic [1:0]                             m_tuser,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [bcal_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [bcal_pkg::VALUE_BITS-1:0]        cfg_data
);

	logic [bcal_pkg::NCH-1:0][bcal_pkg::VALUE_BITS-1:0] readings;
	bcal_pkg::lane_stat_t [bcal_pkg::NCH-1:0]            lane_stat;
	logic [bcal_pkg::NCH-1:0]                            lane_open, lane_pass;
	bcal_pkg::lane_ctrl_t                                lane_ctrl;
	bcal_pkg::merge_t                                    merge;
	bcal_pkg::result_t                                   result, out_item;
	logic                                                take;

	assign readings = s_tdata;
	assign take     = s_tvalid && s_tready;

	// lanes
	for (genvar c = 0; c < bcal_pkg::NCH; c++) begin : g_lane
		if (c < bcal_pkg::CHANNELS) begin : g_on
			bcal_lane u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (lane_ctrl),
				.reading (readings[c]),
				.stat    (lane_stat[c])
			);
		end else begin : g_off
			assign lane_stat[c] = '0;
		end
		assign lane_open[c]    = lane_stat[c].open;
		assign lane_pass[c]    = lane_stat[c].pass;
		assign result.drive[c] = lane_stat[c].drive;
	end

	// phase control and merge
	bcal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.kind      (s_tuser),
		.lane_open (lane_open),
		.lane_pass (lane_pass),
		.lane_ctrl (lane_ctrl),
		.merge     (merge)
	);

	assign result.event_res = merge.event_res;
	assign result.pass_mask = merge.pass_mask;
	assign result.all_pass  = merge.all_pass;

	// output buffer
	bcal_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && merge.has_result),
		.din       (result),
		.ready     (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.dout      (out_item)
	);

	assign m_tuser = out_item.event_res;
	assign m_tdata = bcal_pkg::OUT_DATA_BITS'({out_item.all_pass, out_item.pass_mask,
	                                           out_item.drive});

endmodule

@@ sim/testbench.sv @@
// self-checking bench for the six-lane bisection drive calibrator
`timescale 1ns / 1ps

module testbench;
	import bcal_pkg::*;

	localparam int VALUE_MAX      = (1 << VALUE_BITS) - 1;
	localparam int MASK_LSB       = NCH * VALUE_BITS;
	localparam int ALL_PASS_BIT   = MASK_LSB + NCH;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int RANDOM_REPORTS = 1000;

	// kind code that the block must ignore
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// register write order, matching the register numbering
	localparam logic [CFG_IDX_BITS-1:0] REG_ORDER [6] = '{
		CFG_MIN_EMISSION, CFG_MAX_EMISSION, CFG_PAPER_REFERENCE,
		CFG_PAPER_TOLERANCE, CFG_OPEN_REFERENCE, CFG_OPEN_TOLERANCE
	};

	// settings walked through in the sweep: min, max, paper ref/tol, open ref/tol
	localparam value_t SWEEP [5][6] = '{
		'{value_t'(0), value_t'(VALUE_MAX), value_t'(32768), value_t'(0),
			value_t'(32768), value_t'(0)},
		'{value_t'(0), value_t'(0), value_t'(0), value_t'(VALUE_MAX),
			value_t'(VALUE_MAX), value_t'(VALUE_MAX)},
		'{value_t'(VALUE_MAX), value_t'(VALUE_MAX), value_t'(0), value_t'(0),
			value_t'(0), value_t'(0)},
		'{value_t'(0), value_t'(1), value_t'(1), value_t'(1), value_t'(1), value_t'(1)},
		'{MIN_RESET, MAX_RESET, PAPER_REF_RESET, PAPER_TOL_RESET,
			OPEN_REF_RESET, OPEN_TOL_RESET}
	};

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;
	logic [1:0]               s_tuser;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic [1:0]               m_tuser;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [VALUE_BITS-1:0]    cfg_data;

	multichannel_bisection_calibrator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// mirrored registers and calibration state
	value_t reg_min, reg_max, reg_paper_ref, reg_paper_tol, reg_open_ref, reg_open_tol;
	value_t search_lo [NCH];
	value_t search_hi [NCH];
	value_t kept_drive [NCH];
	phase_t cal_phase;

	// result items the block still owes, oldest first
	result_t owed_reports [$];
	int      reports_predicted;
	int      n_sent;
	int      n_seen;
	int      n_errors;

	// sender and receiver pacing
	int      tx_gap;
	bit      tx_burst;
	bit      rx_burst;
	int      rx_hold;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	task automatic flag_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		n_errors++;
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
	endtask

	function automatic void reset_prediction();
		int c;
		reg_min       = MIN_RESET;
		reg_max       = MAX_RESET;
		reg_paper_ref = PAPER_REF_RESET;
		reg_paper_tol = PAPER_TOL_RESET;
		reg_open_ref  = OPEN_REF_RESET;
		reg_open_tol  = OPEN_TOL_RESET;
		for (c = 0; c < NCH; c++) begin
			search_lo[c]  = '0;
			search_hi[c]  = '0;
			kept_drive[c] = CHOSEN_RESET;
		end
		cal_phase = PH_IDLE;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_BITS-1:0] idx,
			input value_t data);
		case (idx)
			CFG_MIN_EMISSION:    reg_min       = data;
			CFG_MAX_EMISSION:    reg_max       = data;
			CFG_PAPER_REFERENCE: reg_paper_ref = data;
			CFG_PAPER_TOLERANCE: reg_paper_tol = data;
			CFG_OPEN_REFERENCE:  reg_open_ref  = data;
			CFG_OPEN_TOLERANCE:  reg_open_tol  = data;
			default: ;
		endcase
	endfunction

	// midpoints of open lanes, converged low bound elsewhere; 1 while any lane is open
	function automatic bit fill_request(inout result_t r);
		bit                  any_open;
		logic [VALUE_BITS:0] span;
		int                  c;
		any_open = 1'b0;
		for (c = 0; c < CHANNELS; c++) begin
			if (search_lo[c] < search_hi[c]) begin
				span = {1'b0, search_lo[c]} + {1'b0, search_hi[c]};
				r.drive[c] = span[VALUE_BITS:1];
				any_open = 1'b1;
			end else begin
				r.drive[c] = search_lo[c];
			end
		end
		return any_open;
	endfunction

	// per-lane window check of the readings
	function automatic void grade_readings(inout result_t r,
			input logic [IN_DATA_BITS-1:0] rd, input value_t target, input value_t margin);
		value_t x, d;
		int     c;
		r.all_pass = 1'b1;
		for (c = 0; c < CHANNELS; c++) begin
			x = rd[c*VALUE_BITS +: VALUE_BITS];
			d = (x >= target) ? x - target : target - x;
			if (d > margin)
				r.all_pass = 1'b0;
			else
				r.pass_mask[c] = 1'b1;
		end
	endfunction

	// advance the mirrored calibrator by one accepted item
	function automatic void calibrate_step(input logic [1:0] kind,
			input logic [IN_DATA_BITS-1:0] rd);
		result_t             r;
		logic [VALUE_BITS:0] span;
		value_t              mid;
		int                  c;
		r = '0;
		case (kind)
			KIND_PAPER: begin
				for (c = 0; c < NCH; c++) begin
					search_lo[c]  = reg_min;
					search_hi[c]  = reg_max;
					kept_drive[c] = '0;
				end
				cal_phase = fill_request(r) ? PH_SEARCH : PH_FINAL;
				r.event_res = EV_MEASURE;
				owed_reports.push_back(r);
				reports_predicted++;
			end
			KIND_VERIFY: begin
				cal_phase = PH_VERIFY;
				for (c = 0; c < CHANNELS; c++)
					r.drive[c] = kept_drive[c];
				r.event_res = EV_MEASURE;
				owed_reports.push_back(r);
				reports_predicted++;
			end
			KIND_MEAS: begin
				case (cal_phase)
					PH_SEARCH: begin
						for (c = 0; c < CHANNELS; c++) begin
							if (search_lo[c] < search_hi[c]) begin
								span = {1'b0, search_lo[c]} + {1'b0, search_hi[c]};
								mid = span[VALUE_BITS:1];
								if (rd[c*VALUE_BITS +: VALUE_BITS] < reg_paper_ref)
									search_lo[c] = mid + value_t'(1);
								else
									search_hi[c] = mid;
							end
						end
						if (!fill_request(r))
							cal_phase = PH_FINAL;
						r.event_res = EV_MEASURE;
						owed_reports.push_back(r);
						reports_predicted++;
					end
					PH_FINAL: begin
						for (c = 0; c < NCH; c++)
							kept_drive[c] = (c < CHANNELS) ? search_lo[c] : '0;
						for (c = 0; c < CHANNELS; c++)
							r.drive[c] = kept_drive[c];
						grade_readings(r, rd, reg_paper_ref, reg_paper_tol);
						r.event_res = EV_PAPER_DONE;
						cal_phase = PH_IDLE;
						owed_reports.push_back(r);
						reports_predicted++;
					end
					PH_VERIFY: begin
						for (c = 0; c < CHANNELS; c++)
							r.drive[c] = kept_drive[c];
						grade_readings(r, rd, reg_open_ref, reg_open_tol);
						r.event_res = EV_OPEN_DONE;
						cal_phase = PH_IDLE;
						owed_reports.push_back(r);
						reports_predicted++;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	endfunction

	// watch all three channels at every edge: registers, input items, result items
	always @(posedge clk) begin : result_check
		result_t want;
		int      c;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);
			if (s_tvalid && s_tready) begin
				calibrate_step(s_tuser, s_tdata);
				n_seen++;
			end
			if (m_tvalid && m_tready) begin
				if (owed_reports.size() == 0) begin
					flag_mismatch("unexpected result item", 64'(m_tuser), 0);
				end else begin
					want = owed_reports.pop_front();
					if (m_tuser !== want.event_res)
						flag_mismatch("event_res", 64'(m_tuser), 64'(want.event_res));
					for (c = 0; c < NCH; c++)
						if (m_tdata[c*VALUE_BITS +: VALUE_BITS] !== want.drive[c])
							flag_mismatch($sformatf("drive_ch%0d", c),
								64'(m_tdata[c*VALUE_BITS +: VALUE_BITS]),
								64'(want.drive[c]));
					if (m_tdata[MASK_LSB +: NCH] !== want.pass_mask)
						flag_mismatch("pass_mask", 64'(m_tdata[MASK_LSB +: NCH]),
							64'(want.pass_mask));
					if (m_tdata[ALL_PASS_BIT] !== want.all_pass)
						flag_mismatch("all_pass", 64'(m_tdata[ALL_PASS_BIT]),
							64'(want.all_pass));
				end
			end
		end
	end

	// result receiver with random stalls and an optional long hold-off
	initial begin : result_sink
		int stall;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		m_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (rx_hold > 0) begin
					stall = rx_hold;
					rx_hold = 0;
				end else begin
					stall = rx_burst ? 0 : $urandom_range(0, 16);
				end
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
					m_tready <= 1'b1;
				end
			end
		end
	end

	// offer one item, wait for its acceptance and for the mirror to take it in
	task automatic send_item(input logic [1:0] kind, input logic [IN_DATA_BITS-1:0] readings);
		if (tx_gap > 0)
			repeat (tx_gap) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= readings;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_sent++;
		wait (n_seen == n_sent);
		// valid stays up when the next item follows at once
		tx_gap = tx_burst ? 0 : $urandom_range(0, 16);
		if (tx_gap > 0)
			s_tvalid <= 1'b0;
	endtask

	// drop valid, wait for every owed result, then let the pipeline empty
	task automatic settle();
		if (tx_gap == 0) begin
			s_tvalid <= 1'b0;
			tx_gap = 1;
		end
		wait (owed_reports.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [IN_DATA_BITS-1:0] six(input value_t a, b, c, d, e, f);
		return {f, e, d, c, b, a};
	endfunction

	// reading that lands on, just inside or just outside a window, or anywhere
	function automatic value_t near_value(input value_t target, input value_t margin);
		int t, m, v;
		t = int'(target);
		m = int'(margin);
		case ($urandom_range(0, 7))
			0: v = $urandom_range(0, VALUE_MAX);
			1: v = 0;
			2: v = VALUE_MAX;
			3: v = t - m;
			4: v = t + m;
			5: v = t - m - 1;
			6: v = t + m + 1;
			default: v = t - m + $urandom_range(0, 2 * m);
		endcase
		if (v < 0)
			v = 0;
		if (v > VALUE_MAX)
			v = VALUE_MAX;
		return value_t'(v);
	endfunction

	function automatic logic [IN_DATA_BITS-1:0] near_readings(input value_t target,
			input value_t margin);
		logic [IN_DATA_BITS-1:0] rd;
		int                      c;
		for (c = 0; c < NCH; c++)
			rd[c*VALUE_BITS +: VALUE_BITS] = near_value(target, margin);
		return rd;
	endfunction

	// feed measurements until the open calibration or verify completes
	task automatic finish_open_run();
		while (cal_phase != PH_IDLE)
			send_item(KIND_MEAS, near_readings(reg_paper_ref, reg_paper_tol));
	endtask

	// write every register once, only with the block idle
	task automatic load_settings(input value_t mn, mx, pr, pt, orf, ot);
		value_t vals [6];
		int     i;
		finish_open_run();
		settle();
		vals = '{mn, mx, pr, pt, orf, ot};
		for (i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// full paper calibration, optionally followed by a no-paper verify
	task automatic calibrate_run(input bit with_verify);
		send_item(KIND_PAPER, near_readings(reg_paper_ref, reg_paper_tol));
		while (cal_phase != PH_IDLE)
			send_item(KIND_MEAS, near_readings(reg_paper_ref, reg_paper_tol));
		if (with_verify) begin
			send_item(KIND_VERIFY, near_readings(reg_open_ref, reg_open_tol));
			send_item(KIND_MEAS, near_readings(reg_open_ref, reg_open_tol));
		end
	endtask

	// verify against the reset drives, ignored items
	task automatic test_reset_state();
		send_item(KIND_VERIFY, '0);
		send_item(KIND_MEAS, six(4900, 5100, 4899, 5101, 0, value_t'(VALUE_MAX)));
		send_item(KIND_MEAS, {NCH{value_t'(VALUE_MAX)}});
		send_item(KIND_UNUSED, {NCH{value_t'(VALUE_MAX)}});
		send_item(KIND_VERIFY, {NCH{value_t'(VALUE_MAX)}});
		send_item(KIND_MEAS, {NCH{OPEN_REF_RESET}});
	endtask

	// restarts, verify during search, empty and inverted ranges, window edges
	task automatic test_directed_cases();
		logic [IN_DATA_BITS-1:0] mixed;
		mixed = six(0, value_t'(VALUE_MAX), 1099, 1100, 1101, 0);
		load_settings(1000, 1007, 1100, 0, 5000, value_t'(VALUE_MAX));
		// paper start while a search is running
		send_item(KIND_PAPER, '0);
		send_item(KIND_MEAS, mixed);
		send_item(KIND_PAPER, mixed);
		while (cal_phase == PH_SEARCH)
			send_item(KIND_MEAS, mixed);
		send_item(KIND_MEAS, six(1100, 1100, 1099, 1101, 0, value_t'(VALUE_MAX)));
		// verify start abandons the search and uses the cleared drives
		send_item(KIND_PAPER, '0);
		send_item(KIND_MEAS, mixed);
		send_item(KIND_VERIFY, '0);
		send_item(KIND_MEAS, six(0, value_t'(VALUE_MAX), 5000, 1, 2, 3));
		// empty range at the top of the scale
		load_settings(value_t'(VALUE_MAX), value_t'(VALUE_MAX), value_t'(VALUE_MAX),
			value_t'(VALUE_MAX), 0, 0);
		send_item(KIND_PAPER, '1);
		send_item(KIND_MEAS, six(0, value_t'(VALUE_MAX), 0, 1, 32768, 7));
		send_item(KIND_VERIFY, '0);
		send_item(KIND_MEAS, six(0, 0, 0, 0, 0, 1));
		// min above max
		load_settings(value_t'(VALUE_MAX), 0, 0, 0, value_t'(VALUE_MAX), 0);
		send_item(KIND_PAPER, '0);
		send_item(KIND_MEAS, six(0, 1, 2, value_t'(VALUE_MAX), 0, 0));
	endtask

	// a handful of fixed settings, extremes and defaults among them
	task automatic test_setting_sweep();
		int k;
		for (k = 0; k < 5; k++) begin
			load_settings(SWEEP[k][0], SWEEP[k][1], SWEEP[k][2], SWEEP[k][3],
				SWEEP[k][4], SWEEP[k][5]);
			repeat (3) calibrate_run(1'b1);
		end
	endtask

	// long receiver hold-off against a back-to-back sender
	task automatic test_backpressure();
		load_settings(0, value_t'(VALUE_MAX), 32768, 16, 40000, 16);
		tx_burst = 1'b1;
		rx_hold = 300;
		repeat (2) calibrate_run(1'b1);
		tx_burst = 1'b0;
		settle();
	endtask

	// mostly complete runs with random content, some noise and broken runs
	task automatic test_random_traffic();
		int     base, choice, a;
		value_t mn, mx;
		base = reports_predicted;
		while (reports_predicted - base < RANDOM_REPORTS) begin
			if ($urandom_range(0, 99) < 4) begin
				case ($urandom_range(0, 3))
					0: begin
						mn = value_t'($urandom);
						mx = value_t'($urandom);
					end
					1: begin
						a = $urandom_range(0, VALUE_MAX);
						mn = value_t'(a);
						a = a + $urandom_range(1, 64);
						mx = value_t'((a > VALUE_MAX) ? VALUE_MAX : a);
					end
					2: begin
						mn = value_t'($urandom);
						mx = mn;
					end
					default: begin
						mn = value_t'($urandom_range(0, 100));
						mx = value_t'($urandom_range(100, 6000));
					end
				endcase
				load_settings(mn, mx, value_t'($urandom_range(mn, mx)),
					($urandom_range(0, 3) == 0) ? value_t'($urandom)
						: value_t'($urandom_range(0, 300)),
					value_t'($urandom),
					($urandom_range(0, 3) == 0) ? value_t'($urandom)
						: value_t'($urandom_range(0, 300)));
			end
			tx_burst = ($urandom_range(0, 7) == 0);
			rx_burst = ($urandom_range(0, 7) == 0);
			choice = $urandom_range(0, 9);
			if (choice < 6) begin
				calibrate_run(1'($urandom_range(0, 1)));
			end else if (choice < 8) begin
				send_item(KIND_VERIFY, near_readings(reg_open_ref, reg_open_tol));
				send_item(KIND_MEAS, near_readings(reg_open_ref, reg_open_tol));
			end else begin
				// any kind, including ignored ones and starts in mid-run
				repeat ($urandom_range(1, 6))
					send_item(2'($urandom_range(0, 3)),
						near_readings(reg_paper_ref, reg_paper_tol));
			end
		end
		tx_burst = 1'b0;
		rx_burst = 1'b0;
	endtask

	initial begin : main_sequence
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= KIND_PAPER;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_MIN_EMISSION;
		cfg_data  <= '0;
		reports_predicted = 0;
		n_sent   = 0;
		n_seen   = 0;
		n_errors = 0;
		tx_gap   = 1;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		rx_hold  = 0;
		reset_prediction();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed_cases();
		test_setting_sweep();
		test_backpressure();
		test_random_traffic();
		finish_open_run();
		settle();
		if (n_errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/bcal_pkg.sv
rtl/bcal_lane.sv
rtl/bcal_ctrl.sv
rtl/bcal_obuf.sv
rtl/multichannel_bisection_calibrator.sv
sim/testbench.sv
